// ===== rtl/bst_pkg.sv =====
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types, codes and the microcode table of the bounded set table.
// ----------------------------------------------------------------------------
package bst_pkg;

    // Default number of set members
    localparam int CAPACITY_DEF = 16;

    // Field widths fixed by the interface
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STEP_W   = 5;

    // Operation codes carried on func
    typedef enum logic [1:0] {
        OP_CONTAINS = 2'd0,
        OP_INSERT   = 2'd1,
        OP_REMOVE   = 2'd2,
        OP_CLEAR    = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // Jump conditions
    typedef enum logic [3:0] {
        COND_FALL,      // never jump
        COND_ALWAYS,
        COND_NO_START,
        COND_CLEAR,
        COND_INSERT,
        COND_CONTAINS,
        COND_REMOVE,
        COND_END,       // index has reached the member count
        COND_DIFFER,    // fetched member differs from the operand
        COND_FULL
    } cond_t;

    // Datapath actions
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LATCH,      // take a new word, index to zero
        ACT_INC,        // index + 1
        ACT_SHIFT,      // move fetched member down one place, index + 1
        ACT_DEC,        // count - 1
        ACT_APPEND,     // store operand after last member, count + 1
        ACT_CLEAR,      // count to zero
        ACT_DONE_OK,
        ACT_DONE_MISS,
        ACT_DONE_FULL
    } act_t;

    typedef logic [STEP_W-1:0] step_t;

    // One control word of the program
    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    // Flags from the datapath to the sequencer
    typedef struct packed {
        logic start;
        op_t  op;
        logic at_end;
        logic differ;
        logic full;
    } dp_flags_t;

    // Program step addresses
    localparam step_t STEP_IDLE     = 5'd0;
    localparam step_t STEP_DISP     = 5'd1;
    localparam step_t STEP_SRCH     = 5'd2;
    localparam step_t STEP_CMP      = 5'd3;
    localparam step_t STEP_FOUND    = 5'd4;
    localparam step_t STEP_FOUND2   = 5'd5;
    localparam step_t STEP_SHRD     = 5'd6;
    localparam step_t STEP_SHWR     = 5'd7;
    localparam step_t STEP_DEC      = 5'd8;
    localparam step_t STEP_ABSENT   = 5'd9;
    localparam step_t STEP_ABSENT2  = 5'd10;
    localparam step_t STEP_ROOM     = 5'd11;
    localparam step_t STEP_APPEND   = 5'd12;
    localparam step_t STEP_CLR      = 5'd13;
    localparam step_t STEP_R_OK     = 5'd14;
    localparam step_t STEP_R_MISS   = 5'd15;
    localparam step_t STEP_R_FULL   = 5'd16;

    // Microcode ROM: jump to target when cond holds, else fall through
    function automatic ctrl_word_t ucode_rom(input step_t pc);
        ctrl_word_t w;
        begin
            w = '{act: ACT_NONE, cond: COND_ALWAYS, target: STEP_IDLE};
            case (pc)
                STEP_IDLE:    w = '{ACT_LATCH,     COND_NO_START, STEP_IDLE};
                STEP_DISP:    w = '{ACT_NONE,      COND_CLEAR,    STEP_CLR};
                // search: fetch at index, compare next step
                STEP_SRCH:    w = '{ACT_NONE,      COND_END,      STEP_ABSENT};
                STEP_CMP:     w = '{ACT_INC,       COND_DIFFER,   STEP_SRCH};
                // found, index now one past the match
                STEP_FOUND:   w = '{ACT_NONE,      COND_INSERT,   STEP_R_MISS};
                STEP_FOUND2:  w = '{ACT_NONE,      COND_CONTAINS, STEP_R_OK};
                // remove: close the gap one member at a time
                STEP_SHRD:    w = '{ACT_NONE,      COND_END,      STEP_DEC};
                STEP_SHWR:    w = '{ACT_SHIFT,     COND_ALWAYS,   STEP_SHRD};
                STEP_DEC:     w = '{ACT_DEC,       COND_ALWAYS,   STEP_R_OK};
                // absent
                STEP_ABSENT:  w = '{ACT_NONE,      COND_REMOVE,   STEP_R_MISS};
                STEP_ABSENT2: w = '{ACT_NONE,      COND_CONTAINS, STEP_R_MISS};
                STEP_ROOM:    w = '{ACT_NONE,      COND_FULL,     STEP_R_FULL};
                STEP_APPEND:  w = '{ACT_APPEND,    COND_ALWAYS,   STEP_R_OK};
                STEP_CLR:     w = '{ACT_CLEAR,     COND_ALWAYS,   STEP_R_OK};
                // results
                STEP_R_OK:    w = '{ACT_DONE_OK,   COND_ALWAYS,   STEP_IDLE};
                STEP_R_MISS:  w = '{ACT_DONE_MISS, COND_ALWAYS,   STEP_IDLE};
                STEP_R_FULL:  w = '{ACT_DONE_FULL, COND_ALWAYS,   STEP_IDLE};
                default:      w = '{ACT_NONE,      COND_ALWAYS,   STEP_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

// ===== rtl/bst_ram.sv =====
// ----------------------------------------------------------------------------
// bst_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/bst_sequencer.sv =====
// ----------------------------------------------------------------------------
// bst_sequencer
// Step counter, microcode ROM and conditional jump logic.
// ----------------------------------------------------------------------------
module bst_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  bst_pkg::dp_flags_t  flags,
    output bst_pkg::act_t       act,
    output logic                busy
);

    bst_pkg::step_t      pc_reg;
    bst_pkg::step_t      pc_next;
    bst_pkg::ctrl_word_t word;
    logic                take;

    // Fetch current control word
    assign word = bst_pkg::ucode_rom(pc_reg);

    // Jump condition select
    always_comb
    begin
        take = 1'b0;
        unique case (word.cond)
            bst_pkg::COND_FALL:     take = 1'b0;
            bst_pkg::COND_ALWAYS:   take = 1'b1;
            bst_pkg::COND_NO_START: take = !flags.start;
            bst_pkg::COND_CLEAR:    take = (flags.op == bst_pkg::OP_CLEAR);
            bst_pkg::COND_INSERT:   take = (flags.op == bst_pkg::OP_INSERT);
            bst_pkg::COND_CONTAINS: take = (flags.op == bst_pkg::OP_CONTAINS);
            bst_pkg::COND_REMOVE:   take = (flags.op == bst_pkg::OP_REMOVE);
            bst_pkg::COND_END:      take = flags.at_end;
            bst_pkg::COND_DIFFER:   take = flags.differ;
            bst_pkg::COND_FULL:     take = flags.full;
            default:                take = 1'b0;
        endcase
    end

    // Next step
    always_comb
    begin
        pc_next = take ? word.target : bst_pkg::step_t'(pc_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= bst_pkg::STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign act  = word.act;
    assign busy = (pc_reg != bst_pkg::STEP_IDLE);

endmodule

// ===== rtl/bst_datapath.sv =====
// ----------------------------------------------------------------------------
// bst_datapath
// Operand, index and count registers, member memory and result registers.
// ----------------------------------------------------------------------------
module bst_datapath #(
    parameter int CAPACITY = bst_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [1:0]                    func,
    input  logic [bst_pkg::VALUE_W-1:0]   value,
    input  bst_pkg::act_t                 act,
    output bst_pkg::dp_flags_t            flags,
    output logic                          done,
    output logic [1:0]                    status,
    output logic [bst_pkg::COUNT_W-1:0]   count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    bst_pkg::op_t                op_reg,     op_next;
    logic [bst_pkg::VALUE_W-1:0] val_reg,    val_next;
    logic [CW-1:0]               idx_reg,    idx_next;
    logic [CW-1:0]               cnt_reg,    cnt_next;
    logic                        done_reg,   done_next;
    bst_pkg::status_t            status_reg, status_next;
    logic [bst_pkg::COUNT_W-1:0] count_reg,  count_next;

    logic                        we;
    logic [CW-1:0]               idx_prev;
    logic [CW-1:0]               waddr_full;
    logic [bst_pkg::VALUE_W-1:0] wdata;
    logic [bst_pkg::VALUE_W-1:0] rdata;
    logic [31:0]                 cnt_ext;

    // Member store
    bst_ram #(
        .WIDTH (bst_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr_full[AW-1:0]),
        .wdata (wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rdata)
    );

    // Write port: shift writes one below the index, append writes at count
    assign idx_prev   = idx_reg - 1'b1;
    assign we         = (act == bst_pkg::ACT_SHIFT) || (act == bst_pkg::ACT_APPEND);
    assign waddr_full = (act == bst_pkg::ACT_SHIFT) ? idx_prev : cnt_reg;
    assign wdata      = (act == bst_pkg::ACT_SHIFT) ? rdata : val_reg;

    // Flags to the sequencer
    assign flags.start  = start;
    assign flags.op     = op_reg;
    assign flags.at_end = (idx_reg == cnt_reg);
    assign flags.differ = (rdata != val_reg);
    assign flags.full   = (cnt_reg == CW'(CAPACITY));

    // Count as seen on the result port (low bits)
    assign cnt_ext = 32'(cnt_next);

    // Action decode
    always_comb
    begin
        op_next     = op_reg;
        val_next    = val_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        count_next  = count_reg;
        unique case (act) inside
            bst_pkg::ACT_NONE:
            begin
            end
            bst_pkg::ACT_LATCH:
            begin
                if (start)
                begin
                    op_next  = bst_pkg::op_t'(func);
                    val_next = value;
                    idx_next = '0;
                end
            end
            bst_pkg::ACT_INC, bst_pkg::ACT_SHIFT:
            begin
                idx_next = idx_reg + 1'b1;
            end
            bst_pkg::ACT_DEC:
            begin
                cnt_next = cnt_reg - 1'b1;
            end
            bst_pkg::ACT_APPEND:
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            bst_pkg::ACT_CLEAR:
            begin
                cnt_next = '0;
            end
            bst_pkg::ACT_DONE_OK:
            begin
                done_next   = 1'b1;
                status_next = bst_pkg::ST_OK;
                count_next  = cnt_ext[bst_pkg::COUNT_W-1:0];
            end
            bst_pkg::ACT_DONE_MISS:
            begin
                done_next   = 1'b1;
                status_next = bst_pkg::ST_MISS;
                count_next  = cnt_ext[bst_pkg::COUNT_W-1:0];
            end
            bst_pkg::ACT_DONE_FULL:
            begin
                done_next   = 1'b1;
                status_next = bst_pkg::ST_FULL;
                count_next  = cnt_ext[bst_pkg::COUNT_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        val_reg    <= val_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        count_reg  <= count_next;
    end

    assign done   = done_reg;
    assign status = status_reg;
    assign count  = count_reg;

endmodule

// ===== rtl/bounded_set_table.sv =====
// ----------------------------------------------------------------------------
// bounded_set_table
// Set of up to CAPACITY distinct 32-bit values kept in insertion order.
// ----------------------------------------------------------------------------
// Usage:
//   Input word: func (contains, insert, remove, clear) and value. A word is
//   taken on a rising edge with start high and busy low; func and value are
//   sampled on that edge only.
//   Result word: status and count, shown for exactly one cycle with done
//   high. The receiver cannot stall; it must take the word in that cycle.
//   Operation: a microcoded loop over one single-port-read member RAM.
//   Search reads and compares one member at a time; a remove then moves
//   members down one at a time. Busy stays high shortest for clear and
//   longest for a remove of any member of a full set, or an insert into a
//   full set, and done rises as busy falls. One item is in work at a time;
//   busy is high from acceptance until done is raised, and a new word may
//   be started in the cycle done is high.
//   Reset: the member count and the step counter are cleared; no clearing
//   pass runs, the block is ready on the first cycle after reset.
// ----------------------------------------------------------------------------
module bounded_set_table #(
    parameter int CAPACITY = bst_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    func,
    input  logic signed [bst_pkg::VALUE_W-1:0] value,
    output logic                          done,
    output logic [1:0]                    status,
    output logic [bst_pkg::COUNT_W-1:0]   count
);

    bst_pkg::act_t      act;
    bst_pkg::dp_flags_t flags;

    // Program sequencer
    bst_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .act   (act),
        .busy  (busy)
    );

    // Datapath and member store
    bst_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (func),
        .value  ($unsigned(value)),
        .act    (act),
        .flags  (flags),
        .done   (done),
        .status (status),
        .count  (count)
    );

endmodule
